// ===== rtl/slsrs_pkg.sv =====
// Shared types and constants of the load-sharing route selector.
// No dependencies; every other file of the block but slsrs_ram imports this package.
`timescale 1ns / 1ps

package slsrs_pkg;

	localparam int MAX_ROUTES  = 8;
	localparam int TABLE_DEPTH = 128;

	localparam int ROUTE_LIMIT = (MAX_ROUTES < 8) ? MAX_ROUTES : 8;
	localparam int ROUTE_W     = 3;
	localparam int CNT_W       = 4;
	localparam int CODE_W      = 24;
	localparam int ESLS_W      = 7;
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int CFG_W       = 5;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_OPC_OFFSET  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DPC_OFFSET  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DROP_BITS   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_COUNT = 2'd3;

	typedef struct packed {
		logic [4:0]       opc_offset;
		logic [4:0]       dpc_offset;
		logic [1:0]       drop_bits;
		logic [CNT_W-1:0] route_count;
	} cfg_t;

	typedef struct packed {
		logic               norm_ok;
		logic [ROUTE_W-1:0] norm;
		logic               alt_ok;
		logic [ROUTE_W-1:0] alt;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [7:0]        mask;
	} qitem_t;

endpackage

// ===== rtl/slsrs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module slsrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/slsrs_front.sv =====
// Front end: takes message labels and forms the table slot from the folded
// point codes and the SLS. Depends on slsrs_pkg.
`timescale 1ns / 1ps

module slsrs_front (
	input  slsrs_pkg::cfg_t                   cfg,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [slsrs_pkg::CODE_W-1:0]      origin_code,
	input  logic [slsrs_pkg::CODE_W-1:0]      dest_code,
	input  logic [3:0]                        link_selector,
	input  logic [7:0]                        available_mask,
	input  logic                              q_full,
	output logic                              q_push,
	output slsrs_pkg::qitem_t                 q_item
);
	import slsrs_pkg::*;

	logic [CODE_W-1:0] opc_sh;
	logic [CODE_W-1:0] dpc_sh;
	logic [2:0]        od3;
	logic [ESLS_W-1:0] esls;
	logic [ESLS_W-1:0] esls_sh;

	always_comb begin
		opc_sh  = origin_code >> cfg.opc_offset;
		dpc_sh  = dest_code >> cfg.dpc_offset;
		od3     = opc_sh[5:3] ^ opc_sh[2:0] ^ dpc_sh[5:3] ^ dpc_sh[2:0];
		esls    = {od3, link_selector};
		esls_sh = esls >> cfg.drop_bits;
	end

	assign in_stall    = q_full;
	assign q_push      = in_valid && !q_full;
	assign q_item.slot = esls_sh[SLOT_W-1:0];
	assign q_item.mask = available_mask;

endmodule

// ===== rtl/slsrs_queue.sv =====
// Two-entry queue that decouples the front end from the table back end.
// Depends on slsrs_pkg.
`timescale 1ns / 1ps

module slsrs_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  slsrs_pkg::qitem_t push_item,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output slsrs_pkg::qitem_t head
);
	import slsrs_pkg::*;

	qitem_t     slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	assign full      = count_q[1];
	assign not_empty = (count_q != 2'd0);
	assign head      = slot_q[rd_ptr_q];

endmodule

// ===== rtl/slsrs_back.sv =====
// Back end: reads the slot table, picks the route, updates the entry and the
// round-robin pointers, and holds the result. Depends on slsrs_pkg, slsrs_ram.
`timescale 1ns / 1ps

module slsrs_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  slsrs_pkg::cfg_t                cfg,
	input  logic                           q_not_empty,
	input  slsrs_pkg::qitem_t              q_head,
	output logic                           q_pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [slsrs_pkg::ROUTE_W-1:0]  chosen_route,
	output logic                           route_found,
	output logic                           via_alternative,
	output logic [slsrs_pkg::ESLS_W-1:0]   table_slot
);
	import slsrs_pkg::*;

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_CALC = 2'b10
	} back_state_t;

	back_state_t       state_q;
	logic [TABLE_DEPTH-1:0] vld_q;
	logic              vld_s1;
	qitem_t            item_s1;
	logic              assign_ok_q;
	logic [ROUTE_W-1:0] assign_ptr_q;
	logic              send_ok_q;
	logic [ROUTE_W-1:0] send_ptr_q;
	logic              out_valid_q;
	logic [ROUTE_W-1:0] route_q;
	logic              found_q;
	logic              alt_q;
	logic [ESLS_W-1:0] slot_q;

	logic [ENTRY_W-1:0] ram_rdata;
	entry_t            cur;
	entry_t            nxt;
	logic              out_free;
	logic              calc_done;
	logic [CNT_W-1:0]  cnt;
	logic              nv;
	logic              av;
	logic              found;
	logic              via_alt;
	logic [ROUTE_W-1:0] chosen;
	logic              assign_upd;
	logic [ROUTE_W-1:0] assign_nxt;
	logic              send_upd;
	logic [ROUTE_W-1:0] send_nxt;
	logic [CNT_W-1:0]  a_ptr;
	logic [CNT_W-1:0]  p0;
	logic [CNT_W-1:0]  cand_sum;
	logic [CNT_W-1:0]  cand [8];
	logic [7:0]        hit;
	logic              scan_hit;
	logic [CNT_W-1:0]  scan_pick;
	logic [CNT_W-1:0]  scan_last;
	logic              search;

	function automatic logic available_bit(input logic [7:0] mask, input logic [CNT_W-1:0] idx);
		logic r;
		r = (idx < 4'd8) && mask[idx[2:0]];
		return r;
	endfunction

	assign out_free  = !out_valid_q || !out_stall;
	assign q_pop     = (state_q == BK_IDLE) && q_not_empty;
	assign calc_done = (state_q == BK_CALC) && out_free;

	slsrs_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (calc_done),
		.waddr(item_s1.slot),
		.wdata(nxt),
		.re   (q_pop),
		.raddr(q_head.slot),
		.rdata(ram_rdata)
	);

	always_comb begin
		cur       = vld_s1 ? entry_t'(ram_rdata) : '0;
		nxt       = cur;
		cnt       = (cfg.route_count > CNT_W'(ROUTE_LIMIT)) ? CNT_W'(ROUTE_LIMIT)
		                                                    : cfg.route_count;
		nv        = cur.norm_ok && ({1'b0, cur.norm} < cnt);
		av        = cur.alt_ok && ({1'b0, cur.alt} < cnt);
		found     = 1'b0;
		via_alt   = 1'b0;
		chosen    = '0;
		assign_upd = 1'b0;
		send_upd   = 1'b0;
		search     = 1'b0;

		if (assign_ok_q && ({1'b0, assign_ptr_q} < cnt)) begin
			a_ptr = ({1'b0, assign_ptr_q} + 4'd1 == cnt) ? '0 : {1'b0, assign_ptr_q} + 4'd1;
		end else begin
			a_ptr = '0;
		end
		assign_nxt = a_ptr[ROUTE_W-1:0];

		if (send_ok_q && ({1'b0, send_ptr_q} < cnt)) begin
			p0 = ({1'b0, send_ptr_q} + 4'd1 == cnt) ? '0 : {1'b0, send_ptr_q} + 4'd1;
		end else begin
			p0 = '0;
		end

		for (int k = 0; k < 8; k++) begin
			cand_sum = p0 + CNT_W'(k);
			cand[k]  = (cand_sum >= cnt) ? cand_sum - cnt : cand_sum;
			hit[k]   = (CNT_W'(k) < cnt) && available_bit(item_s1.mask, cand[k]);
		end
		scan_hit  = 1'b0;
		scan_pick = '0;
		for (int k = 7; k >= 0; k--) begin
			if (hit[k]) begin
				scan_hit  = 1'b1;
				scan_pick = cand[k];
			end
		end
		scan_last = (p0 == '0) ? cnt - 4'd1 : p0 - 4'd1;

		priority if (nv && item_s1.mask[cur.norm]) begin
			found      = 1'b1;
			chosen     = cur.norm;
			nxt.alt_ok = 1'b0;
			nxt.alt    = '0;
		end else if (av && item_s1.mask[cur.alt]) begin
			found   = 1'b1;
			via_alt = 1'b1;
			chosen  = cur.alt;
		end else begin
			search = 1'b1;
			if (!nv) begin
				if (cnt == '0) begin
					search = 1'b0;
				end else begin
					assign_upd  = 1'b1;
					nxt.norm_ok = 1'b1;
					nxt.norm    = assign_nxt;
					if (item_s1.mask[assign_nxt]) begin
						found  = 1'b1;
						chosen = assign_nxt;
						search = 1'b0;
					end
				end
			end
			if (search) begin
				send_upd = 1'b1;
				if (scan_hit) begin
					found      = 1'b1;
					via_alt    = 1'b1;
					chosen     = scan_pick[ROUTE_W-1:0];
					nxt.alt_ok = 1'b1;
					nxt.alt    = scan_pick[ROUTE_W-1:0];
				end
			end
		end
		send_nxt = scan_hit ? scan_pick[ROUTE_W-1:0] : scan_last[ROUTE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1 <= q_head;
		end
		if (calc_done) begin
			route_q <= found ? chosen : '0;
			found_q <= found;
			alt_q   <= found && via_alt;
			slot_q  <= ESLS_W'(item_s1.slot);
		end
		if (calc_done && assign_upd) begin
			assign_ptr_q <= assign_nxt;
		end
		if (calc_done && send_upd) begin
			send_ptr_q <= send_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			vld_q       <= '0;
			vld_s1      <= 1'b0;
			assign_ok_q <= 1'b0;
			send_ok_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				vld_s1 <= vld_q[q_head.slot];
			end
			if (calc_done) begin
				vld_q[item_s1.slot] <= 1'b1;
				if (assign_upd) begin
					assign_ok_q <= 1'b1;
				end
				if (send_upd) begin
					send_ok_q <= 1'b1;
				end
			end
			if (calc_done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				BK_IDLE: begin
					if (q_pop) begin
						state_q <= BK_CALC;
					end
				end
				BK_CALC: begin
					if (calc_done) begin
						state_q <= BK_IDLE;
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign chosen_route    = route_q;
	assign route_found     = found_q;
	assign via_alternative = alt_q;
	assign table_slot      = slot_q;

endmodule

// ===== rtl/sls_loadshare_route_selector_unit.sv =====
// Top level of the load-sharing route selector: configuration registers,
// front end, queue and table back end. Depends on slsrs_pkg and all slsrs_* modules.
// Channel  | Direction | Handshake           | Payload
// in       | input     | in_valid / in_stall   | origin_code, dest_code, link_selector, available_mask
// out      | output    | out_valid / out_stall | chosen_route, route_found, via_alternative, table_slot
// cfg      | input     | cfg_we                | cfg_index, cfg_data
// An item passes through the back-end states BK_IDLE, which issues the slot table read, and
// BK_CALC, which chooses the route and writes the entry back; no new item is taken until
// BK_CALC is done. A two-entry queue lets the front end keep taking items meanwhile.
// Reset clears the per-slot valid bits at once, so the table is usable right after reset.
// A stalled output holds the back end in BK_CALC until the previous result is taken.
`timescale 1ns / 1ps

module sls_loadshare_route_selector_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [slsrs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [slsrs_pkg::CFG_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [slsrs_pkg::CODE_W-1:0]        origin_code,
	input  logic [slsrs_pkg::CODE_W-1:0]        dest_code,
	input  logic [3:0]                          link_selector,
	input  logic [7:0]                          available_mask,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [slsrs_pkg::ROUTE_W-1:0]       chosen_route,
	output logic                                route_found,
	output logic                                via_alternative,
	output logic [slsrs_pkg::ESLS_W-1:0]        table_slot
);
	import slsrs_pkg::*;

	cfg_t   cfg_q;
	logic   q_full;
	logic   q_push;
	qitem_t q_in;
	logic   q_pop;
	logic   q_not_empty;
	qitem_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OPC_OFFSET:  cfg_q.opc_offset  <= cfg_data;
				CFG_DPC_OFFSET:  cfg_q.dpc_offset  <= cfg_data;
				CFG_DROP_BITS:   cfg_q.drop_bits   <= cfg_data[1:0];
				CFG_ROUTE_COUNT: cfg_q.route_count <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	slsrs_front u_front (
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.origin_code   (origin_code),
		.dest_code     (dest_code),
		.link_selector (link_selector),
		.available_mask(available_mask),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (q_in)
	);

	slsrs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(q_in),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.head     (q_head)
	);

	slsrs_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_not_empty    (q_not_empty),
		.q_head         (q_head),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.chosen_route   (chosen_route),
		.route_found    (route_found),
		.via_alternative(via_alternative),
		.table_slot     (table_slot)
	);

endmodule
